/* src/lesf_pkg.sv */
// Shared widths, register indexes and defaults of the largest empty square finder.
package lesf_pkg;

    // Fixed field widths.
    localparam int CHAR_W      = 8;
    localparam int CFG_COLS_W  = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_COLUMNS   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OBSTACLE_CHAR = 1'd1;

    // Register reset values.
    localparam logic [CFG_COLS_W-1:0] MAP_COLUMNS_RESET   = 11'd1;
    localparam logic [CHAR_W-1:0]     OBSTACLE_CHAR_RESET = 8'd111;

    // Default grid limits.
    localparam int DEFAULT_MAX_COLS = 1024;
    localparam int DEFAULT_MAX_ROWS = 1024;

endpackage

/* src/largest_empty_square_finder_unit.sv */
// Top level of the largest empty square finder: position counters, line store and square update.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_we                 cfg_index, cfg_data
//   in        in         in_valid / in_ready    cell_char, last_cell
//   out       out        out_valid / out_ready  square_size, top_row, left_col, too_many_rows
//
// The block takes one cell word per cycle unless the update stage holds. A cell passes
// an input stage, where the column and row counters assign its position and the line
// store is read, and an update stage, where its square size is formed and the best
// square is kept. A grid's result word is registered as its last cell leaves the update
// stage. Reset clears all control state but not the line store, as a row is always
// written before it is read. A result word not taken holds the next grid's last cell.
module largest_empty_square_finder_unit
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = DEFAULT_MAX_COLS,
    parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int SIZE_W  = $clog2(MAX_COLS + 1),
    localparam int RCNT_W  = $clog2(MAX_ROWS + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CHAR_W-1:0]      cell_char,
    input  logic                   last_cell,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SIZE_W-1:0]      square_size,
    output logic [ROW_W-1:0]       top_row,
    output logic [COL_W-1:0]       left_col,
    output logic                   too_many_rows
);

    // Configuration registers.
    logic [CFG_COLS_W-1:0] map_columns_reg;
    logic [CHAR_W-1:0]     obstacle_char_reg;

    // Input stage: position of the next cell.
    logic [COL_W-1:0]  col_cnt_reg,  col_cnt_next;
    logic [RCNT_W-1:0] row_cnt_reg,  row_cnt_next;

    // Update stage registers.
    logic              s1_valid_reg, s1_valid_next;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_last_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic              s1_first_row_reg;
    logic              s1_ovf_reg;
    logic              byp_hit_reg;
    logic [SIZE_W-1:0] byp_data_reg;
    logic [SIZE_W-1:0] rd_data_reg;

    // Running state of the current grid.
    logic [SIZE_W-1:0] left_size_reg;
    logic [SIZE_W-1:0] diag_size_reg;
    logic [SIZE_W-1:0] best_size_reg;
    logic [ROW_W-1:0]  best_top_reg;
    logic [COL_W-1:0]  best_left_reg;
    logic              ovf_flag_reg;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [SIZE_W-1:0] out_size_reg;
    logic [ROW_W-1:0]  out_top_reg;
    logic [COL_W-1:0]  out_left_reg;
    logic              out_ovf_reg;

    // Line store holding the sizes of the row above.
    logic [SIZE_W-1:0] line_mem [MAX_COLS];

    logic              in_accept;
    logic              s1_adv;
    logic              s1_upd;
    logic [SIZE_W-1:0] eff_cols;
    logic [SIZE_W-1:0] col_inc;
    logic              col_wrap;
    logic [SIZE_W-1:0] up_size;
    logic [SIZE_W-1:0] diag_size;
    logic [SIZE_W-1:0] left_size;
    logic [SIZE_W-1:0] min_ul;
    logic [SIZE_W-1:0] min_all;
    logic [SIZE_W-1:0] cell_size;
    logic              better;
    logic [ROW_W-1:0]  cand_top;
    logic [COL_W-1:0]  cand_left;
    logic [SIZE_W-1:0] fin_size;
    logic [ROW_W-1:0]  fin_top;
    logic [COL_W-1:0]  fin_left;

    // The update stage holds only when it carries a last cell and the previous result
    // word is still waiting.
    assign s1_adv    = s1_valid_reg && !(s1_last_reg && out_valid_reg && !out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;

    // Column count after clamping: zero acts as one, anything above the store acts as
    // the store's width.
    always_comb
    begin
        if (map_columns_reg == '0)
        begin
            eff_cols = SIZE_W'(1);
        end
        else if (32'(map_columns_reg) > 32'(MAX_COLS))
        begin
            eff_cols = SIZE_W'(MAX_COLS);
        end
        else
        begin
            eff_cols = SIZE_W'(map_columns_reg);
        end
    end

    assign col_inc  = SIZE_W'(col_cnt_reg) + SIZE_W'(1);
    assign col_wrap = (col_inc >= eff_cols);

    // Position counters advance per accepted cell; the last cell restarts the grid.
    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (in_accept)
        begin
            if (last_cell)
            begin
                col_cnt_next = '0;
                row_cnt_next = '0;
            end
            else if (col_wrap)
            begin
                col_cnt_next = '0;
                if (row_cnt_reg < RCNT_W'(MAX_ROWS))
                begin
                    row_cnt_next = row_cnt_reg + RCNT_W'(1);
                end
            end
            else
            begin
                col_cnt_next = col_inc[COL_W-1:0];
            end
        end
    end

    // Neighbor sizes. Cells outside the grid count as zero. The size written by the
    // cell in the update stage is forwarded when the next cell reads the same column.
    always_comb
    begin
        if (s1_first_row_reg)
        begin
            up_size = '0;
        end
        else if (byp_hit_reg)
        begin
            up_size = byp_data_reg;
        end
        else
        begin
            up_size = rd_data_reg;
        end
        diag_size = (s1_first_row_reg || s1_col_reg == '0) ? '0 : diag_size_reg;
        left_size = (s1_col_reg == '0) ? '0 : left_size_reg;
        min_ul    = (left_size < up_size) ? left_size : up_size;
        min_all   = (min_ul < diag_size) ? min_ul : diag_size;
        cell_size = (s1_char_reg == obstacle_char_reg) ? '0 : min_all + SIZE_W'(1);
    end

    // Cells in rows beyond the limit only raise the overflow flag.
    assign s1_upd    = s1_adv && !s1_ovf_reg;
    assign better    = cell_size > best_size_reg;
    assign cand_top  = ROW_W'(32'(s1_row_reg) + 32'd1 - 32'(cell_size));
    assign cand_left = COL_W'(32'(s1_col_reg) + 32'd1 - 32'(cell_size));

    // Best square including the cell now in the update stage; only a strictly larger
    // size replaces it, which keeps the topmost, then leftmost square.
    always_comb
    begin
        if (s1_upd && better)
        begin
            fin_size = cell_size;
            fin_top  = cand_top;
            fin_left = cand_left;
        end
        else
        begin
            fin_size = best_size_reg;
            fin_top  = best_top_reg;
            fin_left = best_left_reg;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_columns_reg   <= MAP_COLUMNS_RESET;
            obstacle_char_reg <= OBSTACLE_CHAR_RESET;
            col_cnt_reg       <= '0;
            row_cnt_reg       <= '0;
            s1_valid_reg      <= 1'b0;
            byp_hit_reg       <= 1'b0;
            left_size_reg     <= '0;
            diag_size_reg     <= '0;
            best_size_reg     <= '0;
            best_top_reg      <= '0;
            best_left_reg     <= '0;
            ovf_flag_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAP_COLUMNS:   map_columns_reg   <= cfg_data[CFG_COLS_W-1:0];
                    REG_OBSTACLE_CHAR: obstacle_char_reg <= cfg_data[CHAR_W-1:0];
                    default:           ;
                endcase
            end

            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;

            if (in_accept)
            begin
                byp_hit_reg <= s1_upd && (s1_col_reg == col_cnt_reg);
            end

            if (s1_adv)
            begin
                if (s1_last_reg)
                begin
                    left_size_reg <= '0;
                    diag_size_reg <= '0;
                    best_size_reg <= '0;
                    best_top_reg  <= '0;
                    best_left_reg <= '0;
                    ovf_flag_reg  <= 1'b0;
                end
                else
                begin
                    if (s1_upd)
                    begin
                        left_size_reg <= cell_size;
                        diag_size_reg <= up_size;
                    end
                    best_size_reg <= fin_size;
                    best_top_reg  <= fin_top;
                    best_left_reg <= fin_left;
                    ovf_flag_reg  <= ovf_flag_reg || s1_ovf_reg;
                end
            end
        end
    end

    // Payload of the update stage and the result word.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_char_reg      <= cell_char;
            s1_last_reg      <= last_cell;
            s1_col_reg       <= col_cnt_reg;
            s1_row_reg       <= ROW_W'(row_cnt_reg);
            s1_first_row_reg <= (row_cnt_reg == '0);
            s1_ovf_reg       <= (row_cnt_reg >= RCNT_W'(MAX_ROWS));
            byp_data_reg     <= cell_size;
        end
        if (s1_adv && s1_last_reg)
        begin
            out_size_reg <= fin_size;
            out_top_reg  <= fin_top;
            out_left_reg <= fin_left;
            out_ovf_reg  <= ovf_flag_reg || s1_ovf_reg;
        end
    end

    // Line store: written by the update stage, read with a registered port at accept.
    always_ff @(posedge clk)
    begin
        if (s1_upd)
        begin
            line_mem[s1_col_reg] <= cell_size;
        end
        if (in_accept)
        begin
            rd_data_reg <= line_mem[col_cnt_reg];
        end
    end

    assign out_valid     = out_valid_reg;
    assign square_size   = out_size_reg;
    assign top_row       = out_top_reg;
    assign left_col      = out_left_reg;
    assign too_many_rows = out_ovf_reg;

endmodule

/* src/lesf_checker.sv */
// Port-level checks for the largest empty square finder and their binding.
module lesf_checker
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = DEFAULT_MAX_COLS,
    parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int SIZE_W  = $clog2(MAX_COLS + 1)
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              last_cell,
    input logic              out_valid,
    input logic              out_ready,
    input logic [SIZE_W-1:0] square_size,
    input logic [ROW_W-1:0]  top_row,
    input logic [COL_W-1:0]  left_col
);

    // A stalled result word holds its size.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(square_size))
        else $error("result word changed while stalled");

    // A last cell taken while the output is empty yields a word after the update stage and the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_cell && !out_valid |=> ##1 out_valid)
        else $error("last cell produced no result word");

    // With no empty square the position reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && square_size == '0 |-> top_row == '0 && left_col == '0)
        else $error("position reported for an empty result");

    // The reported square lies inside the column range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(left_col) + 32'(square_size) <= 32'(MAX_COLS))
        else $error("square extends past the last column");

endmodule

bind largest_empty_square_finder_unit lesf_checker #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
) u_lesf_checker (.*);

/* verif/tb_largest_empty_square_finder_unit.sv */
// Self-checking testbench for the largest empty square finder unit.
module tb_largest_empty_square_finder_unit
    import lesf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Grid limits of the instance under test and the port widths that follow from them.
    localparam int MAX_COLS = DEFAULT_MAX_COLS;
    localparam int MAX_ROWS = DEFAULT_MAX_ROWS;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int SIZE_W   = $clog2(MAX_COLS + 1);

    localparam int          SETTLE_CYCLES = 4;
    localparam int          LONG_HOLD     = 300;
    localparam int          RANDOM_ITEMS  = 400;
    localparam int          MAX_REPORTS   = 10;
    localparam longint      CYCLE_LIMIT   = 2_000_000;

    // One result word of the block.
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [ROW_W-1:0]  top;
        logic [COL_W-1:0]  left;
        logic              overflow;
    } square_t;

    // Scoreboard: it tracks the grid state the block should hold, predicts the square of
    // every grid whose last cell is accepted, and compares result words against that.
    class square_scoreboard;
        int unsigned       col_setting;
        logic [CHAR_W-1:0] blocked_char;
        int unsigned       upper_sizes [MAX_COLS];
        int unsigned       left_sz, diag_sz, col_pos, row_pos;
        int unsigned       best_sz, best_row, best_col;
        bit                overflow;
        square_t           pending_q [$];
        int                mismatches;

        function new();
            col_setting  = 32'(MAP_COLUMNS_RESET);
            blocked_char = OBSTACLE_CHAR_RESET;
            foreach (upper_sizes[i])
                upper_sizes[i] = 0;
            mismatches = 0;
            start_grid();
        endfunction

        function void start_grid();
            left_sz  = 0;
            diag_sz  = 0;
            col_pos  = 0;
            row_pos  = 0;
            best_sz  = 0;
            best_row = 0;
            best_col = 0;
            overflow = 0;
        endfunction

        // Row width in effect: zero behaves as one, anything wider is clamped.
        function int unsigned width();
            if (col_setting == 0)
                return 1;
            if (col_setting > MAX_COLS)
                return MAX_COLS;
            return col_setting;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MAP_COLUMNS)
                col_setting = 32'(data);
            else if (idx == REG_OBSTACLE_CHAR)
                blocked_char = data[CHAR_W-1:0];
        endfunction

        function void note_cell(logic [CHAR_W-1:0] ch, logic last);
            int unsigned cols, up, diag, lft, sz;
            square_t     res;
            cols = width();
            if (row_pos >= MAX_ROWS)
            begin
                overflow = 1;
            end
            else
            begin
                up   = (row_pos == 0) ? 0 : upper_sizes[col_pos];
                diag = (row_pos == 0 || col_pos == 0) ? 0 : diag_sz;
                lft  = (col_pos == 0) ? 0 : left_sz;
                if (ch == blocked_char)
                begin
                    sz = 0;
                end
                else
                begin
                    sz = (lft < up) ? lft : up;
                    if (diag < sz)
                        sz = diag;
                    sz++;
                end
                diag_sz              = up;
                left_sz              = sz;
                upper_sizes[col_pos] = sz;
                // Only a strictly larger square replaces the kept one.
                if (sz > best_sz)
                begin
                    best_sz  = sz;
                    best_row = row_pos;
                    best_col = col_pos;
                end
            end
            if (col_pos + 1 >= cols)
            begin
                col_pos = 0;
                if (row_pos < MAX_ROWS)
                    row_pos++;
            end
            else
            begin
                col_pos++;
            end
            if (last)
            begin
                res.size     = SIZE_W'(best_sz);
                res.top      = (best_sz > 0) ? ROW_W'(best_row + 1 - best_sz) : '0;
                res.left     = (best_sz > 0) ? COL_W'(best_col + 1 - best_sz) : '0;
                res.overflow = overflow;
                pending_q.push_back(res);
                start_grid();
            end
        endfunction

        function void check_result(square_t got);
            square_t want;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result word with no grid pending: %s %0d %0d %0d %0d",
                             $time, "size/top/left/flag", got.size, got.top, got.left,
                             got.overflow);
                return;
            end
            want = pending_q.pop_front();
            if (got.size !== want.size || got.top !== want.top || got.left !== want.left ||
                got.overflow !== want.overflow)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: expected size %0d top %0d left %0d flag %0d, %s",
                             $time, want.size, want.top, want.left, want.overflow,
                             $sformatf("got size %0d top %0d left %0d flag %0d",
                                       got.size, got.top, got.left, got.overflow));
            end
        endfunction
    endclass

    // Clock, reset and every block input start at known values.
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [CHAR_W-1:0]      cell_char = '0;
    logic                   last_cell = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [SIZE_W-1:0]      square_size;
    logic [ROW_W-1:0]       top_row;
    logic [COL_W-1:0]       left_col;
    logic                   too_many_rows;

    // When no_idle is set, neither side inserts gaps. hold_request asks the receiver
    // process for one long stretch with out_ready low; the receiver clears it on start.
    bit                no_idle      = 1'b0;
    bit                hold_request = 1'b0;
    longint unsigned   cycle_count  = 0;
    square_scoreboard  sb;

    largest_empty_square_finder_unit #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cell_char     (cell_char),
        .last_cell     (last_cell),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .square_size   (square_size),
        .top_row       (top_row),
        .left_col      (left_col),
        .too_many_rows (too_many_rows)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Gap lengths: mostly none, often a few cycles, now and then a long pause.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // A cell character that is blocked with the given percentage, else any free code.
    function automatic logic [CHAR_W-1:0] pick_char(int unsigned block_pct);
        logic [CHAR_W-1:0] ch;
        if ($urandom_range(0, 99) < block_pct)
            return sb.blocked_char;
        ch = CHAR_W'($urandom_range(0, 255));
        if (ch == sb.blocked_char)
            ch = ~ch;
        return ch;
    endfunction

    // Offers one cell word and holds it until it is accepted. With no gap to follow,
    // valid stays high so that the next call can present its word on the same edge.
    task automatic send_cell(input logic [CHAR_W-1:0] ch, input logic last);
        int unsigned gap;
        in_valid  <= 1'b1;
        cell_char <= ch;
        last_cell <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A run of random cells; only a closed run marks its final cell as the last one.
    task automatic send_grid(input int unsigned n_cells, input int unsigned block_pct,
                             input bit closed);
        for (int unsigned i = 0; i < n_cells; i++)
            send_cell(pick_char(block_pct), closed && (i == n_cells - 1));
    endtask

    // Pattern cells: '#' blocked, '0' and 'F' the extreme codes, anything else random free.
    // The final character of the pattern is the last cell of the grid.
    task automatic send_pattern(input string pattern);
        logic [CHAR_W-1:0] ch;
        for (int i = 0; i < pattern.len(); i++)
        begin
            case (pattern[i])
                "#":     ch = sb.blocked_char;
                "0":     ch = 8'h00;
                "F":     ch = 8'hFF;
                default: ch = pick_char(0);
            endcase
            send_cell(ch, i == pattern.len() - 1);
        end
    endtask

    // Stops the sender and waits until every predicted square has come back, then lets
    // the pipeline empty of cells that carry no result of their own.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the trailing cycle keeps consecutive writes apart.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        sb.write_reg(idx, value[CFG_DATA_W-1:0]);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Obstacle writes carry random junk above the character bits, which must be ignored.
    task automatic write_obstacle(input int unsigned code);
        write_reg(REG_OBSTACLE_CHAR, code | ($urandom_range(0, 7) << CHAR_W));
    endtask

    // Both channels are sampled at the rising edge, before any of this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_cell(cell_char, last_cell);
            if (out_valid && out_ready)
                sb.check_result('{square_size, top_row, left_col, too_many_rows});
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles without finishing", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random ready pattern in spans of random length, and on request one long
    // hold-off that is counted here so the sender can keep pushing words meanwhile.
    initial
    begin : receiver
        int unsigned span;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 2) != 0);
                span = no_idle ? 1 : pick_gap() + 1;
                repeat (span) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int unsigned random_items, cols, rows, n_cells, block_pct, col_val, obs_val, roll;
        bit          mid_grid;

        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values: one column, 'o' blocked. The first free cell
        // sits in row one, so the square is found there.
        send_pattern("#..");
        wait_idle();

        // A fully free three by three grid using the extreme character codes.
        write_reg(REG_MAP_COLUMNS, 3);
        send_pattern("0F...0F..");
        // Nothing but obstacles, and the last cell ends the grid in the middle of a row.
        send_pattern("##");
        wait_idle();

        // Two equal squares side by side: the first one found must be kept.
        write_obstacle(0);
        write_reg(REG_MAP_COLUMNS, 5);
        send_pattern("..#....#..");
        wait_idle();

        // A column setting of zero behaves as a single column.
        write_reg(REG_MAP_COLUMNS, 0);
        write_obstacle(255);
        send_pattern("..");
        wait_idle();

        // A setting above the limit is clamped to the widest row: the one free cell comes
        // after a full row of obstacles, so it opens row one only if the rows wrap there.
        write_reg(REG_MAP_COLUMNS, 2047);
        for (int i = 0; i <= MAX_COLS; i++)
            send_cell((i == MAX_COLS) ? pick_char(0) : sb.blocked_char, i == MAX_COLS);
        wait_idle();

        // Too many rows: a single free cell in the final legal row, then free cells past
        // the row limit that must only raise the flag.
        write_reg(REG_MAP_COLUMNS, 1);
        for (int i = 0; i < MAX_ROWS + 6; i++)
            send_cell((i < MAX_ROWS - 1) ? sb.blocked_char : pick_char(0), i == MAX_ROWS + 5);
        wait_idle();

        // Narrowing the rows while a grid is under way: the cell that sits past the new
        // width closes its row.
        write_reg(REG_MAP_COLUMNS, 6);
        send_grid(10, 0, 1'b0);
        wait_idle();
        write_reg(REG_MAP_COLUMNS, 3);
        send_grid(6, 20, 1'b1);
        wait_idle();

        // Back pressure: the receiver holds off for a long stretch while tiny grids keep
        // coming with no gaps, so result words pile up and the input stalls.
        write_reg(REG_MAP_COLUMNS, 2);
        write_obstacle($urandom_range(0, 255));
        no_idle      = 1'b1;
        hold_request = 1'b1;
        while (hold_request)
            @(posedge clk);
        repeat (40) send_grid($urandom_range(2, 6), 30, 1'b1);
        no_idle = 1'b0;

        // Random phases. Each one drains the block, picks new settings and sends a few
        // grids; now and then a grid is left open and finished under narrower rows.
        random_items = 0;
        mid_grid     = 1'b0;
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            roll = $urandom_range(0, 99);
            if (mid_grid)
                col_val = $urandom_range(1, sb.width());
            else if (roll < 4)
                col_val = 0;
            else if (roll < 6)
                col_val = 2047;
            else if (roll < 7)
                col_val = MAX_COLS;
            else if (roll < 8)
                col_val = $urandom_range(65, 2046);
            else if (roll < 40)
                col_val = $urandom_range(1, 3);
            else
                col_val = $urandom_range(4, 16);
            roll = $urandom_range(0, 9);
            obs_val = (roll == 0) ? 0 : (roll == 1) ? 255 : $urandom_range(0, 255);
            case ($urandom_range(0, 3))
                0: write_reg(REG_MAP_COLUMNS, col_val);
                1: write_obstacle(obs_val);
                2:
                begin
                    write_obstacle(obs_val);
                    write_reg(REG_MAP_COLUMNS, col_val);
                end
                default:
                begin
                    write_reg(REG_MAP_COLUMNS, col_val);
                    write_obstacle(obs_val);
                end
            endcase
            no_idle = ($urandom_range(0, 4) == 0);
            cols    = sb.width();

            // Wide rows get a single short grid so they do not dominate the run.
            repeat ((cols > 64) ? 1 : $urandom_range(1, 5))
            begin
                rows    = (cols > 64) ? 1 : $urandom_range(1, (cols <= 4) ? 10 : 6);
                n_cells = rows * cols;
                if (cols > 64)
                    n_cells = $urandom_range(1, 64);
                else if ($urandom_range(0, 3) == 0)
                    n_cells -= $urandom_range(0, cols - 1);
                case ($urandom_range(0, 4))
                    0:       block_pct = 0;
                    1:       block_pct = 5;
                    2:       block_pct = 15;
                    3:       block_pct = 35;
                    default: block_pct = 80;
                endcase
                send_grid(n_cells, block_pct, 1'b1);
                random_items += n_cells;
            end

            mid_grid = 1'b0;
            if ($urandom_range(0, 4) == 0)
            begin
                n_cells = $urandom_range(1, (cols > 64) ? 64 : 2 * cols);
                send_grid(n_cells, 15, 1'b0);
                random_items += n_cells;
                mid_grid = 1'b1;
            end
        end
        no_idle = 1'b0;

        // Let the last words drain, then give stray result words time to show up.
        wait_idle();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            if (sb.pending_q.size() != 0)
                $display("%0d predicted squares never arrived", sb.pending_q.size());
            $display("%0d mismatching result words", sb.mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
